// ----- src/sitda_pkg.sv -----
// ============================================================================
// sitda_pkg: shared types and constants for the signed decimal text converter
// Character codes, output field widths, BCD adjust constants, controller state
// and the command and status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package sitda_pkg;

    // ASCII codes used in the text
    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_MINUS = 7'd45;

    // Output field widths
    localparam int CHAR_W      = 7;
    localparam int TEXT_LEN_W  = 4;
    localparam int OUT_TDATA_W = 16;

    // BCD digit adjust during binary to BCD shifting
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CONV  = 5'b00010,
        S_NORM  = 5'b00100,
        S_SIGN  = 5'b01000,
        S_DIGIT = 5'b10000
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture magnitude and sign
        logic conv;        // one binary to BCD shift step
        logic norm;        // drop one leading zero digit
        logic emit_sign;   // send the minus sign
        logic emit_digit;  // send the top digit
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic conv_last;   // this is the final shift step
        logic top_zero;    // top BCD digit is zero
        logic more_digits; // more than one digit kept
        logic negative;    // item was negative
        logic last_digit;  // one digit left to send
        logic out_free;    // output register can take a character
    } t_stat;

endpackage

`default_nettype wire

// ----- src/sitda_ctrl.sv -----
// ============================================================================
// sitda_ctrl: sequencing controller
// Steps one item through load, BCD conversion, leading zero removal and
// character output.
// ============================================================================
`default_nettype none

module sitda_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  sitda_pkg::t_stat    i_stat,
    output sitda_pkg::t_cmd     o_cmd
);
    import sitda_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register: reset to S_IDLE, else take the next state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                if (i_stat.conv_last) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (i_stat.top_zero && i_stat.more_digits) begin
                    o_cmd.norm = 1'b1;
                end else if (i_stat.negative) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_SIGN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_stat.last_digit) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ----- src/sitda_dpath.sv -----
// ============================================================================
// sitda_dpath: conversion datapath
// Magnitude shift register, BCD digit register with add-3 adjust, digit
// counters and the output character register.
// ============================================================================
`default_nettype none

module sitda_dpath #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire [DATA_WIDTH-1:0]           i_value,
    input  sitda_pkg::t_cmd                i_cmd,
    output sitda_pkg::t_stat               o_stat,
    input  wire                            i_out_ready,
    output logic                           o_out_valid,
    output logic [sitda_pkg::CHAR_W-1:0]   o_char_code,
    output logic [sitda_pkg::TEXT_LEN_W-1:0] o_text_length,
    output logic                           o_last_char
);
    import sitda_pkg::*;

    // Enough decimal digits for a DATA_WIDTH-bit magnitude
    localparam int NDIG  = (DATA_WIDTH * 302) / 1000 + 1;
    localparam int BCD_W = NDIG * 4;
    localparam int NW    = $clog2(NDIG + 2);
    localparam int CW    = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      w_adj;
    logic [CW-1:0]         r_bitcnt;
    logic [NW-1:0]         r_ndig;
    logic [NW-1:0]         r_rem;
    logic                  r_neg;
    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_char;
    logic [TEXT_LEN_W-1:0] r_len;
    logic                  r_last;
    logic [3:0]            w_top;
    logic [NW:0]           w_len_full;
    logic                  w_in_neg;

    assign w_in_neg   = i_value[DATA_WIDTH-1];
    assign w_top      = r_bcd[BCD_W-1 -: 4];
    assign w_len_full = {1'b0, r_ndig} + (NW + 1)'(r_neg);

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*4 +: 4] >= BCD_ADJ_MIN) begin
                w_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + BCD_ADJ;
            end else begin
                w_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    // Magnitude, digits and counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin    <= w_in_neg ? (~i_value + 1'b1) : i_value;
            r_neg    <= w_in_neg;
            r_bcd    <= '0;
            r_bitcnt <= CW'(DATA_WIDTH);
            r_ndig   <= NW'(NDIG);
            r_rem    <= NW'(NDIG);
        end else if (i_cmd.conv) begin
            r_bcd    <= {w_adj[BCD_W-2:0], r_bin[DATA_WIDTH-1]};
            r_bin    <= {r_bin[DATA_WIDTH-2:0], 1'b0};
            r_bitcnt <= r_bitcnt - 1'b1;
        end else if (i_cmd.norm) begin
            r_bcd  <= {r_bcd[BCD_W-5:0], 4'd0};
            r_ndig <= r_ndig - 1'b1;
            r_rem  <= r_rem - 1'b1;
        end else if (i_cmd.emit_digit) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
            r_rem <= r_rem - 1'b1;
        end
    end

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output character payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_char <= CHAR_MINUS;
            r_len  <= w_len_full[TEXT_LEN_W-1:0];
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= CHAR_ZERO + {3'b000, w_top};
            r_len  <= w_len_full[TEXT_LEN_W-1:0];
            r_last <= (r_rem == NW'(1));
        end
    end

    assign o_stat.conv_last   = (r_bitcnt == CW'(1));
    assign o_stat.top_zero    = (w_top == 4'd0);
    assign o_stat.more_digits = (r_ndig > NW'(1));
    assign o_stat.negative    = r_neg;
    assign o_stat.last_digit  = (r_rem == NW'(1));
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_char_code   = r_char;
    assign o_text_length = r_len;
    assign o_last_char   = r_last;

endmodule

`default_nettype wire

// ----- src/signed_int_to_decimal_ascii.sv -----
// ============================================================================
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Streams the decimal text of one signed integer, one character per item.
// ============================================================================
// Each input item is a DATA_WIDTH-bit two's complement integer; the block
// sends its decimal text most significant character first, a minus sign ahead
// of negative values, one character per output item, with tlast on the final
// character and the total text length on every character. One item is worked
// at a time: shift-and-add-3 binary to BCD conversion over its DATA_WIDTH
// bits, then leading zero digits are dropped (up to the digit register width
// less one, 9 at the default width) until the search ends, then the
// characters are sent while the output side takes them; output stalls hold
// the item. Dropped zeros and sent digits always add up to the digit
// register width. The single shared shift-add BCD register means the next
// item waits for the current one. s_axis_tready is high only between
// items, and the last character may still wait in the output register while
// the next item is taken.
`default_nettype none

module signed_int_to_decimal_ascii #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // [DATA_WIDTH-1:0] value, rest zero fill
    input  wire [((DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // [6:0] char_code, [10:7] text_length, [15:11] zero fill
    output logic [sitda_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // last_char
    output logic                               m_axis_tlast
);
    import sitda_pkg::*;

    t_cmd                  w_cmd;
    t_stat                 w_stat;
    logic [CHAR_W-1:0]     w_char;
    logic [TEXT_LEN_W-1:0] w_len;

    // Sequencing
    sitda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Conversion and output register
    sitda_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (s_axis_tdata[DATA_WIDTH-1:0]),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_char_code   (w_char),
        .o_text_length (w_len),
        .o_last_char   (m_axis_tlast)
    );

    // Pack output fields
    assign m_axis_tdata = {(OUT_TDATA_W - CHAR_W - TEXT_LEN_W)'(0), w_len, w_char};

    // Only one item in flight: input closes right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    // Final character is always a digit
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tdata[CHAR_W-1:0] >= CHAR_ZERO) &&
            (m_axis_tdata[CHAR_W-1:0] <= CHAR_ZERO + 7'd9))
        else $error("last character is not a digit");

    // Minus sign never ends the text
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[CHAR_W-1:0] == CHAR_MINUS) |-> !m_axis_tlast)
        else $error("minus sign flagged as last character");

    // Commands are mutually exclusive
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command at once");

endmodule

`default_nettype wire
